FILE: src/pdist_pkg.sv
// Package for the planar point distance block: constants, the pipeline stage type and the
// single-precision add, multiply, compare and rounding functions used by each stage.
// It depends on nothing else.
package pdist_pkg;

   localparam int NumStages = 13;

   localparam logic [31:0] SEED_MAGIC = 32'h5f375a86;
   localparam logic [31:0] FP_HALF    = 32'h3f000000;
   localparam logic [31:0] FP_ONE_P5  = 32'h3fc00000;
   localparam logic [31:0] CANON_NAN  = 32'h7fc00000;

   typedef struct packed {
      logic        byp;
      logic [31:0] bval;
      logic [31:0] s;
      logic [31:0] h;
      logic [31:0] r;
      logic [31:0] t;
   } stage_type;

   function automatic logic is_nan(input logic [31:0] a);
      is_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [31:0] a);
      is_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
   endfunction

   function automatic logic is_zero(input logic [31:0] a);
      is_zero = (a[30:0] == 31'd0);
   endfunction

   function automatic logic [5:0] lzc50(input logic [49:0] m);
      int i;
      lzc50 = 6'd50;
      for (i = 0; i < 50; i++) begin
         if (m[i]) begin
            lzc50 = 6'(49 - i);
         end
      end
   endfunction

   // The value is m * 2^e; m must be non-zero. Rounds to nearest, ties to even.
   function automatic logic [31:0] round_pack(input logic sgn, input logic [49:0] m,
                                              input logic signed [11:0] e);
      logic [5:0]         lz;
      logic [49:0]        n;
      logic [49:0]        n2;
      logic [49:0]        msk;
      logic signed [11:0] be;
      logic [11:0]        sh;
      logic [7:0]         fe;
      logic               xst;
      logic               inc;
      logic [30:0]        mag;
      lz  = lzc50(m);
      n   = m << lz;
      be  = 12'sd176 - $signed({6'd0, lz}) + e;
      xst = 1'b0;
      msk = '0;
      sh  = '0;
      if (be >= 12'sd1) begin
         n2 = n;
         fe = be[7:0];
      end else begin
         sh = 12'(12'sd1 - be);
         fe = 8'd0;
         if (sh >= 12'd50) begin
            n2  = '0;
            xst = |n;
         end else begin
            msk = (50'd1 << sh[5:0]) - 50'd1;
            xst = |(n & msk);
            n2  = n >> sh[5:0];
         end
      end
      inc = n2[25] & ((|n2[24:0]) | xst | n2[26]);
      mag = {fe, n2[48:26]} + {30'd0, inc};
      if (be >= 12'sd255) begin
         round_pack = {sgn, 8'hff, 23'd0};
      end else begin
         round_pack = {sgn, mag};
      end
   endfunction

   function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
      logic               sgn;
      logic [23:0]        ma;
      logic [23:0]        mb;
      logic [9:0]         ea;
      logic [9:0]         eb;
      logic [47:0]        p;
      logic signed [11:0] e;
      sgn = a[31] ^ b[31];
      ma  = {(a[30:23] != 8'd0), a[22:0]};
      mb  = {(b[30:23] != 8'd0), b[22:0]};
      ea  = (a[30:23] == 8'd0) ? 10'd1 : {2'd0, a[30:23]};
      eb  = (b[30:23] == 8'd0) ? 10'd1 : {2'd0, b[30:23]};
      p   = ma * mb;
      e   = $signed({2'd0, ea}) + $signed({2'd0, eb}) - 12'sd300;
      if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a)))
      begin
         fmul = CANON_NAN;
      end else if (is_inf(a) || is_inf(b)) begin
         fmul = {sgn, 8'hff, 23'd0};
      end else if (is_zero(a) || is_zero(b)) begin
         fmul = {sgn, 31'd0};
      end else begin
         fmul = round_pack(sgn, {2'd0, p}, e);
      end
   endfunction

   function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
      logic [31:0]        x;
      logic [31:0]        y;
      logic [23:0]        mx;
      logic [23:0]        my;
      logic [7:0]         ex;
      logic [7:0]         ey;
      logic [7:0]         d;
      logic [49:0]        xw;
      logic [49:0]        yw0;
      logic [49:0]        yw;
      logic [49:0]        msk;
      logic [49:0]        m;
      logic signed [11:0] e;
      if (a[30:0] >= b[30:0]) begin
         x = a;
         y = b;
      end else begin
         x = b;
         y = a;
      end
      mx  = {(x[30:23] != 8'd0), x[22:0]};
      my  = {(y[30:23] != 8'd0), y[22:0]};
      ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      d   = ex - ey;
      xw  = {1'b0, mx, 25'd0};
      yw0 = {1'b0, my, 25'd0};
      msk = '0;
      if (d >= 8'd50) begin
         yw = {49'd0, |my};
      end else begin
         msk = (50'd1 << d[5:0]) - 50'd1;
         yw  = (yw0 >> d[5:0]) | {49'd0, |(yw0 & msk)};
      end
      if (x[31] == y[31]) begin
         m = xw + yw;
      end else begin
         m = xw - yw;
      end
      e = $signed({4'd0, ex}) - 12'sd175;
      if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]))) begin
         fadd = CANON_NAN;
      end else if (is_inf(a)) begin
         fadd = a;
      end else if (is_inf(b)) begin
         fadd = b;
      end else if (m == 50'd0) begin
         fadd = {x[31] & y[31], 31'd0};
      end else begin
         fadd = round_pack(x[31], m, e);
      end
   endfunction

   function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
      fsub = fadd(a, {~b[31], b[30:0]});
   endfunction

   function automatic logic feq(input logic [31:0] a, input logic [31:0] b);
      feq = !is_nan(a) && !is_nan(b) && ((a == b) || (is_zero(a) && is_zero(b)));
   endfunction

   function automatic logic [31:0] order_key(input logic [31:0] a);
      order_key = a[31] ? ~a : {1'b1, a[30:0]};
   endfunction

   function automatic logic fgt(input logic [31:0] a, input logic [31:0] b);
      fgt = !is_nan(a) && !is_nan(b) && !(is_zero(a) && is_zero(b)) &&
            (order_key(a) > order_key(b));
   endfunction

   // |a - b| given d = a - b: d when a > b, otherwise the value of b - a.
   function automatic logic [31:0] absd(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] d);
      if (fgt(a, b)) begin
         absd = d;
      end else if (is_zero(d)) begin
         absd = {(is_zero(a) && is_zero(b)) ? (b[31] & ~a[31]) : 1'b0, 31'd0};
      end else begin
         absd = {~d[31], d[30:0]};
      end
   endfunction

   function automatic logic [31:0] canon(input logic [31:0] a);
      canon = is_nan(a) ? CANON_NAN : a;
   endfunction

endpackage

FILE: src/planar_point_distance.sv
// Top level of the planar point distance block: a thirteen-stage floating-point pipeline.
// It depends on pdist_pkg for the stage type, the constants and the arithmetic functions.
//
// Usage: each request beat carries two points as single-precision x,y pairs and yields
// exactly one response beat holding their approximate Euclidean distance. When the y values
// compare equal the result is |dx|, when the x values do, |dy|; otherwise the sum of the
// squared differences goes through a seeded reciprocal square root with two Newton steps.
// The pipeline has thirteen stages with at most one floating-point add or multiply in series
// in each, and one beat is accepted in every cycle in which the output register is not held
// by a receiver stall. The last stage is the output register.
// When the receiver stalls while the output register holds a beat, the whole pipeline holds;
// req_tready falls only while that beat has not been taken, and nothing is lost or repeated.
// Reset clears every valid bit, so the response channel is empty after reset.
module planar_point_distance (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // src_x, src_y, tar_x, tar_y from the lowest bit up
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata   // distance
);

   localparam int NS = pdist_pkg::NumStages;

   logic                 adv;
   logic [NS:1]          vld_ff;
   logic [NS:1]          vld_in;
   pdist_pkg::stage_type st_ff [1:NS];
   pdist_pkg::stage_type st_in [1:NS];
   logic [31:0]          sx;
   logic [31:0]          sy;
   logic [31:0]          tx;
   logic [31:0]          ty;
   logic [31:0]          dx;
   logic [31:0]          dy;

   assign adv        = !vld_ff[NS] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NS];
   assign rsp_tdata  = st_ff[NS].t;

   assign sx = req_tdata[31:0];
   assign sy = req_tdata[63:32];
   assign tx = req_tdata[95:64];
   assign ty = req_tdata[127:96];
   assign dx = pdist_pkg::fsub(sx, tx);
   assign dy = pdist_pkg::fsub(sy, ty);

   always_comb begin
      vld_in[1]     = req_tvalid;
      st_in[1].byp  = pdist_pkg::feq(sy, ty) || pdist_pkg::feq(sx, tx);
      st_in[1].bval = pdist_pkg::feq(sy, ty) ? pdist_pkg::absd(sx, tx, dx)
                                              : pdist_pkg::absd(sy, ty, dy);
      st_in[1].s    = dx;
      st_in[1].t    = dy;
      st_in[1].h    = '0;
      st_in[1].r    = '0;
      for (int k = 2; k <= NS; k++) begin
         vld_in[k] = vld_ff[k-1];
         st_in[k]  = st_ff[k-1];
         unique case (k)
            2: begin
               st_in[k].s = pdist_pkg::fmul(st_ff[k-1].s, st_ff[k-1].s);
               st_in[k].t = pdist_pkg::fmul(st_ff[k-1].t, st_ff[k-1].t);
            end
            3: begin
               st_in[k].s = pdist_pkg::fadd(st_ff[k-1].s, st_ff[k-1].t);
            end
            4: begin
               st_in[k].h = pdist_pkg::fmul(st_ff[k-1].s, pdist_pkg::FP_HALF);
               st_in[k].r = pdist_pkg::SEED_MAGIC - {1'b0, st_ff[k-1].s[31:1]};
            end
            5, 9: begin
               st_in[k].t = pdist_pkg::fmul(st_ff[k-1].h, st_ff[k-1].r);
            end
            6, 10: begin
               st_in[k].t = pdist_pkg::fmul(st_ff[k-1].t, st_ff[k-1].r);
            end
            7, 11: begin
               st_in[k].t = pdist_pkg::fsub(pdist_pkg::FP_ONE_P5, st_ff[k-1].t);
            end
            8, 12: begin
               st_in[k].r = pdist_pkg::fmul(st_ff[k-1].r, st_ff[k-1].t);
            end
            default: begin
               st_in[k].t = pdist_pkg::canon(st_ff[k-1].byp ? st_ff[k-1].bval
                              : pdist_pkg::fmul(st_ff[k-1].s, st_ff[k-1].r));
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 1; k <= NS; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid directly after reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[1])
      else $error("accepted beat did not enter the first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   a_nan_canonical: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!pdist_pkg::is_nan(rsp_tdata) || rsp_tdata == pdist_pkg::CANON_NAN))
      else $error("non-canonical NaN on the response");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for planar_point_distance: random and directed point pairs with
// idle and stall phases, checked against a bit-exact single-precision distance predictor.
// It depends on the RTL of planar_point_distance and on pdist_pkg.
module testbench;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;

   logic [127:0] pending_points[$];
   logic [31:0]  expected_distances[$];
   int           send_idle_pct;
   int           recv_stall_pct;
   int           holdoff_left;
   int           holdoff_request;
   int           cycle_count;
   bit           failed;

   planar_point_distance uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic bit sp_nan(input logic [31:0] a);
      return (a[30:23] == 8'hff) && (a[22:0] != 0);
   endfunction

   function automatic bit sp_inf(input logic [31:0] a);
      return (a[30:23] == 8'hff) && (a[22:0] == 0);
   endfunction

   // Rounds sg * m * 2^e to single precision, nearest with ties to even.
   function automatic logic [31:0] sp_round(input bit sg, input logic [299:0] m, input int e);
      int           msb;
      int           lsb_exp;
      int           drop;
      int           biased;
      logic [299:0] kept;
      logic [299:0] rest;
      logic [299:0] halfway;
      msb = -1;
      for (int i = 0; i < 300; i++) begin
         if (m[i]) msb = i;
      end
      if (msb < 0) return {sg, 31'd0};
      lsb_exp = msb + e - 23;
      if (lsb_exp < -149) lsb_exp = -149;
      drop = lsb_exp - e;
      if (drop <= 0) begin
         kept = m << (-drop);
      end else begin
         kept    = m >> drop;
         rest    = m & ((300'd1 << drop) - 300'd1);
         halfway = 300'd1 << (drop - 1);
         if (rest > halfway || (rest == halfway && kept[0])) kept = kept + 300'd1;
      end
      if (kept == (300'd1 << 24)) begin
         kept = kept >> 1;
         lsb_exp++;
      end
      biased = kept[23] ? lsb_exp + 150 : 0;
      if (biased >= 255) return {sg, 8'hff, 23'd0};
      return {sg, biased[7:0], kept[22:0]};
   endfunction

   function automatic void sp_split(input logic [31:0] a, output logic [299:0] m,
                                    output int e);
      m = '0;
      if (a[30:23] == 0) begin
         m[22:0] = a[22:0];
         e       = -149;
      end else begin
         m[23:0] = {1'b1, a[22:0]};
         e       = int'(a[30:23]) - 150;
      end
   endfunction

   function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
      logic [299:0] ma;
      logic [299:0] mb;
      int           ea;
      int           eb;
      bit           sg;
      sg = a[31] ^ b[31];
      if (sp_nan(a) || sp_nan(b)) return pdist_pkg::CANON_NAN;
      if ((sp_inf(a) && b[30:0] == 0) || (sp_inf(b) && a[30:0] == 0))
         return pdist_pkg::CANON_NAN;
      if (sp_inf(a) || sp_inf(b)) return {sg, 8'hff, 23'd0};
      sp_split(a, ma, ea);
      sp_split(b, mb, eb);
      return sp_round(sg, ma * mb, ea + eb);
   endfunction

   function automatic logic [31:0] sp_sub(input logic [31:0] a, input logic [31:0] nb);
      logic [31:0]  b;
      logic [299:0] ma;
      logic [299:0] mb;
      logic [299:0] m;
      int           ea;
      int           eb;
      int           e;
      bit           sg;
      b = {~nb[31], nb[30:0]};
      if (sp_nan(a) || sp_nan(b)) return pdist_pkg::CANON_NAN;
      if (sp_inf(a) && sp_inf(b)) return (a[31] == b[31]) ? a : pdist_pkg::CANON_NAN;
      if (sp_inf(a)) return a;
      if (sp_inf(b)) return b;
      sp_split(a, ma, ea);
      sp_split(b, mb, eb);
      e  = (ea < eb) ? ea : eb;
      ma = ma << (ea - e);
      mb = mb << (eb - e);
      if (a[31] == b[31]) begin
         m  = ma + mb;
         sg = a[31];
      end else if (ma >= mb) begin
         m  = ma - mb;
         sg = a[31];
      end else begin
         m  = mb - ma;
         sg = b[31];
      end
      if (m == 0) return {a[31] & b[31], 31'd0};
      return sp_round(sg, m, e);
   endfunction

   function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
      return sp_sub(a, {~b[31], b[30:0]});
   endfunction

   function automatic logic [31:0] sp_key(input logic [31:0] a);
      return a[31] ? ~a : {1'b1, a[30:0]};
   endfunction

   function automatic bit sp_equal(input logic [31:0] a, input logic [31:0] b);
      if (sp_nan(a) || sp_nan(b)) return 1'b0;
      return (a == b) || (a[30:0] == 0 && b[30:0] == 0);
   endfunction

   function automatic bit sp_greater(input logic [31:0] a, input logic [31:0] b);
      if (sp_nan(a) || sp_nan(b) || (a[30:0] == 0 && b[30:0] == 0)) return 1'b0;
      return sp_key(a) > sp_key(b);
   endfunction

   function automatic logic [31:0] sp_abs_gap(input logic [31:0] a, input logic [31:0] b);
      return sp_greater(a, b) ? sp_sub(a, b) : sp_sub(b, a);
   endfunction

   function automatic logic [31:0] refine_rsqrt(input logic [31:0] r, input logic [31:0] h);
      return sp_mul(r, sp_sub(pdist_pkg::FP_ONE_P5, sp_mul(sp_mul(h, r), r)));
   endfunction

   function automatic logic [31:0] predict_distance(input logic [127:0] pts);
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] tx;
      logic [31:0] ty;
      logic [31:0] dx;
      logic [31:0] dy;
      logic [31:0] sq;
      logic [31:0] hs;
      logic [31:0] est;
      logic [31:0] span;
      {ty, tx, sy, sx} = pts;
      if (sp_equal(sy, ty)) begin
         span = sp_abs_gap(sx, tx);
      end else if (sp_equal(sx, tx)) begin
         span = sp_abs_gap(sy, ty);
      end else begin
         dx   = sp_sub(sx, tx);
         dy   = sp_sub(sy, ty);
         sq   = sp_add(sp_mul(dx, dx), sp_mul(dy, dy));
         hs   = sp_mul(sq, pdist_pkg::FP_HALF);
         est  = pdist_pkg::SEED_MAGIC - (sq >> 1);
         est  = refine_rsqrt(refine_rsqrt(est, hs), hs);
         span = sp_mul(sq, est);
      end
      return sp_nan(span) ? pdist_pkg::CANON_NAN : span;
   endfunction

   function automatic logic [31:0] random_coord();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(9))
         0: v[30:23] = 8'hff;
         1: v[30:23] = 8'h00;
         2: v[30:23] = 8'(120 + $urandom_range(15));
         3: v = {v[31], 31'd0};
         default: v[30:23] = 8'(100 + $urandom_range(60));
      endcase
      return v;
   endfunction

   function automatic logic [127:0] random_points();
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] tx;
      logic [31:0] ty;
      sx = random_coord();
      sy = random_coord();
      tx = random_coord();
      ty = random_coord();
      case ($urandom_range(9))
         0: ty = sy;
         1: tx = sx;
         2: ty = {~sy[31], sy[30:0]};
         3: tx = sx ^ 32'($urandom_range(7));
         4: tx = $urandom;
         default: ;
      endcase
      return {ty, tx, sy, sx};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) expected_distances.push_back(predict_distance(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_points.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= 0;
      end else if (holdoff_request > 0 && holdoff_left == 0) begin
         holdoff_left <= holdoff_request;
         rsp_tready   <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (holdoff_left > 0) holdoff_request <= 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_distances.size() == 0) begin
            $display("%0t: unexpected beat, actual %h", $time, rsp_tdata);
            failed = 1'b1;
         end else if (rsp_tdata !== expected_distances[0]) begin
            $display("%0t: distance mismatch, expected %h actual %h", $time,
                     expected_distances[0], rsp_tdata);
            failed = 1'b1;
            void'(expected_distances.pop_front());
         end else begin
            void'(expected_distances.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("planar_point_distance regression: fail");
         $finish;
      end
   end

   task automatic drain();
      while (pending_points.size() > 0 || req_tvalid || expected_distances.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [31:0] specials[12];
      specials = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000, 32'h7fc00001,
                   32'h00000001, 32'h807fffff, 32'h7f7fffff, 32'hff7fffff, 32'h3f800000,
                   32'hbf800000, 32'h1f000000};
      failed          = 1'b0;
      cycle_count     = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      holdoff_request = 0;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      rsp_tready      = 1'b0;
      reset           = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      pending_points.push_back({32'h80000000, 32'h80000000, 32'h00000000, 32'h00000000});
      pending_points.push_back({32'h00000000, 32'h80000000, 32'h80000000, 32'h00000000});
      pending_points.push_back({32'h40000000, 32'h3f800000, 32'h40000000, 32'hc0400000});
      pending_points.push_back({32'h40a00000, 32'h3f800000, 32'h3f800000, 32'hc0400000});
      pending_points.push_back({32'h40800000, 32'h00000000, 32'h00000000, 32'h40400000});
      pending_points.push_back({32'h7f800000, 32'h7f800000, 32'h00000000, 32'h3f800000});
      pending_points.push_back({32'hff800000, 32'h7f800000, 32'h3f800000, 32'h00000000});
      pending_points.push_back({32'h7fc00000, 32'h3f800000, 32'h7fc00000, 32'h00000000});
      pending_points.push_back({32'h7f7fffff, 32'hff7fffff, 32'hff7fffff, 32'h7f7fffff});
      pending_points.push_back({32'h00000001, 32'h80000001, 32'h00000003, 32'h00000002});
      pending_points.push_back({32'h807fffff, 32'h00000000, 32'h007fffff, 32'h80000001});
      pending_points.push_back({32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
      pending_points.push_back({32'h1f000001, 32'h1f000000, 32'h1f000001, 32'h1f000000});
      for (int i = 0; i < 12; i++) begin
         pending_points.push_back({specials[(i + 3) % 12], specials[(i + 7) % 12],
                                   specials[(i + 5) % 12], specials[i]});
      end
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 63 : 16) : 0;
         recv_stall_pct = (phase == 2) ? 63 : ((phase == 3) ? 16 : 0);
         for (int i = 0; i < 210; i++) pending_points.push_back(random_points());
         if (phase == 0) begin
            repeat (20) @(posedge clock);
            holdoff_request = 300;
         end
         drain();
      end

      repeat (40) @(posedge clock);
      if (!failed) begin
         $display("planar_point_distance regression: pass");
      end else begin
         $display("planar_point_distance regression: fail");
      end
      $finish;
   end
endmodule
